// ===== src/sysex_message_framer_top_macros.svh =====
// Assertion shorthands shared by the framer modules.
`ifndef SYSEX_MESSAGE_FRAMER_TOP_MACROS_SVH
`define SYSEX_MESSAGE_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/smf_pkg.sv =====
`timescale 1ns / 1ps
package smf_pkg;

    // Request selector codes on the input channel
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Fixed message bytes
    localparam logic [7:0] BYTE_SOX   = 8'hf0;
    localparam logic [7:0] BYTE_MAKER = 8'h41;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_MODEL = 8'h6b;
    localparam logic [7:0] CMD_READ   = 8'h11;
    localparam logic [7:0] CMD_WRITE  = 8'h12;
    localparam logic [7:0] BYTE_EOX   = 8'hf7;

    localparam logic [6:0] DEVICE_ID_RESET = 7'd16;

    // Index of the final byte of each message kind
    localparam logic [4:0] LAST_IDX_WRITE = 5'd10;
    localparam logic [4:0] LAST_IDX_READ  = 5'd16;
    localparam logic [4:0] LAST_IDX_DATA  = 5'd0;
    localparam logic [4:0] LAST_IDX_CLOSE = 5'd2;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_DATA,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  last_idx;
        logic [31:0] address;
        logic [31:0] read_size;
        logic [6:0]  data;
        logic [6:0]  csum;
    } t_desc;

    // Byte at position idx of the run described by d.
    function automatic logic [7:0] f_msg_byte(t_desc d, logic [4:0] idx, logic [6:0] dev_id);
        logic [7:0] b;
        b = BYTE_EOX;
        case (d.kind)
            KIND_DATA: begin
                case (idx)
                    5'd0:    b = {1'b0, d.data};
                    5'd1:    b = {1'b0, d.csum};
                    default: b = BYTE_EOX;
                endcase
            end
            KIND_WRITE, KIND_READ: begin
                case (idx)
                    5'd0:    b = BYTE_SOX;
                    5'd1:    b = BYTE_MAKER;
                    5'd2:    b = {1'b0, dev_id};
                    5'd3:    b = BYTE_ZERO;
                    5'd4:    b = BYTE_ZERO;
                    5'd5:    b = BYTE_MODEL;
                    5'd6:    b = (d.kind == KIND_READ) ? CMD_READ : CMD_WRITE;
                    5'd7:    b = d.address[31:24];
                    5'd8:    b = d.address[23:16];
                    5'd9:    b = d.address[15:8];
                    5'd10:   b = d.address[7:0];
                    5'd11:   b = d.read_size[31:24];
                    5'd12:   b = d.read_size[23:16];
                    5'd13:   b = d.read_size[15:8];
                    5'd14:   b = d.read_size[7:0];
                    5'd15:   b = {1'b0, d.csum};
                    default: b = BYTE_EOX;
                endcase
            end
            default: b = BYTE_EOX;
        endcase
        return b;
    endfunction

endpackage

// ===== src/smf_if.sv =====
`timescale 1ns / 1ps
// Request channel: one beat per request item.
interface smf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] read_size;
    logic [6:0]  data_byte;
    logic        data_last;

    modport source (output valid, req_type, address, read_size, data_byte, data_last,
                    input ready);
    modport sink   (input valid, req_type, address, read_size, data_byte, data_last,
                    output ready);
endinterface

// Byte channel: one beat per message byte.
interface smf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ===== src/smf_intake.sv =====
`timescale 1ns / 1ps
`include "sysex_message_framer_top_macros.svh"
module smf_intake (
    input  logic                i_clk,
    input  logic                i_rst_n,
    smf_req_if.sink             i_req,
    input  logic                i_take,
    output smf_pkg::t_desc      o_desc,
    output logic                o_desc_valid
);

    logic [6:0]     r_sum;
    logic           r_in_msg;
    logic           r_valid;
    smf_pkg::t_desc r_desc;

    logic [6:0]     n_sum;
    logic           n_in_msg;
    logic           n_emit;
    smf_pkg::t_desc n_desc;

    logic           accept;
    logic [6:0]     addr_sum;
    logic [6:0]     size_sum;
    logic [6:0]     data_sum;

    assign i_req.ready = !r_valid || i_take;
    assign accept      = i_req.valid && i_req.ready;

    // Low seven bits of each byte feed the checksum
    assign addr_sum = i_req.address[30:24] + i_req.address[22:16]
                    + i_req.address[14:8]  + i_req.address[6:0];
    assign size_sum = i_req.read_size[30:24] + i_req.read_size[22:16]
                    + i_req.read_size[14:8]  + i_req.read_size[6:0];
    assign data_sum = r_sum + i_req.data_byte;

    always_comb begin
        n_sum            = r_sum;
        n_in_msg         = r_in_msg;
        n_emit           = 1'b0;
        n_desc.kind      = smf_pkg::KIND_DATA;
        n_desc.last_idx  = smf_pkg::LAST_IDX_DATA;
        n_desc.address   = i_req.address;
        n_desc.read_size = i_req.read_size;
        n_desc.data      = i_req.data_byte;
        n_desc.csum      = 7'd0;
        case (i_req.req_type)
            smf_pkg::REQ_WRITE: begin
                n_emit          = 1'b1;
                n_desc.kind     = smf_pkg::KIND_WRITE;
                n_desc.last_idx = smf_pkg::LAST_IDX_WRITE;
                n_sum           = addr_sum;
                n_in_msg        = 1'b1;
            end
            smf_pkg::REQ_DATA: begin
                // Drop data beats that arrive with no message open
                if (r_in_msg) begin
                    n_emit      = 1'b1;
                    n_sum       = data_sum;
                    n_desc.csum = 7'd0 - data_sum;
                    if (i_req.data_last) begin
                        n_desc.last_idx = smf_pkg::LAST_IDX_CLOSE;
                        n_sum           = 7'd0;
                        n_in_msg        = 1'b0;
                    end
                end
            end
            smf_pkg::REQ_READ: begin
                n_emit          = 1'b1;
                n_desc.kind     = smf_pkg::KIND_READ;
                n_desc.last_idx = smf_pkg::LAST_IDX_READ;
                n_desc.csum     = 7'd0 - (addr_sum + size_sum);
                n_sum           = 7'd0;
                n_in_msg        = 1'b0;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= 7'd0;
            r_in_msg <= 1'b0;
            r_valid  <= 1'b0;
        end else if (accept) begin
            r_sum    <= n_sum;
            r_in_msg <= n_in_msg;
            r_valid  <= n_emit;
        end else if (i_take) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc       = r_desc;
    assign o_desc_valid = r_valid;

    `SMF_ASSERT_NOW(a_sum_clear_when_closed, i_clk, i_rst_n, !r_in_msg, r_sum == 7'd0, "running sum nonzero with no open message")
    `SMF_ASSERT_NEXT(a_ignored_beat_no_desc, i_clk, i_rst_n, accept && !n_emit, !r_valid, "ignored request left a descriptor")

endmodule

// ===== src/smf_serializer.sv =====
`timescale 1ns / 1ps
`include "sysex_message_framer_top_macros.svh"
module smf_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smf_pkg::t_desc      i_desc,
    input  logic                i_desc_valid,
    input  logic [6:0]          i_dev_id,
    output logic                o_take,
    smf_byte_if.source          o_res
);

    logic [4:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       out_load;
    logic       at_end;

    assign out_load = !r_out_valid || o_res.ready;
    assign at_end   = (r_idx == i_desc.last_idx);
    assign o_take   = i_desc_valid && out_load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 5'd0;
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= i_desc_valid;
            if (i_desc_valid) begin
                r_idx <= at_end ? 5'd0 : r_idx + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && i_desc_valid) begin
            r_out_byte <= smf_pkg::f_msg_byte(i_desc, r_idx, i_dev_id);
            r_out_last <= at_end;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.out_byte = r_out_byte;
    assign o_res.out_last = r_out_last;

    `SMF_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, i_desc_valid, r_idx <= i_desc.last_idx, "byte index past end of run")
    `SMF_ASSERT_NEXT(a_idx_rewinds, i_clk, i_rst_n, o_take, r_idx == 5'd0, "byte index not rewound after run")

endmodule

// ===== src/sysex_message_framer_top.sv =====
`timescale 1ns / 1ps
// System-exclusive message framer.
// Request channel i_req carries one item per beat: write start, data byte or
// read request. Byte channel o_res carries the serialized message one byte
// per beat; out_last marks the final byte caused by one request.
// Config: i_cfg_wr_en / i_cfg_wr_data load the 7-bit device id (third header
// byte); write it only while the framer is idle.
// The first byte of a request goes through the descriptor register, then the
// output register.
// Throughput: one output byte per cycle while o_res.ready is high. A data byte
// yields one byte, a closing data byte three, a write start eleven and a read
// request seventeen; the serializer's byte counter sets that figure. The next
// request is taken in the same cycle the last byte of the current one enters the
// output register: back-to-back data bytes go at one per cycle while not stalled.
// Ignored requests (data with no open message, selector 3) are accepted and
// produce no bytes.
// Reset: synchronous, active low. Clears the open-message flag, the running
// sum and both valid flags; the device id returns to 16.
// Stall: when o_res.ready is low the output byte holds, the serializer
// stops, and i_req.ready drops once the descriptor register is full.
module sysex_message_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    smf_req_if.sink     i_req,
    smf_byte_if.source  o_res
);

    logic [6:0]     r_dev_id;
    smf_pkg::t_desc desc;
    logic           desc_valid;
    logic           take;

    // Device id register: hold until a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id <= smf_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_id <= i_cfg_wr_data;
        end
    end

    // Register the request, update the message state, build the byte-run descriptor
    smf_intake u_intake (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_take       (take),
        .o_desc       (desc),
        .o_desc_valid (desc_valid)
    );

    // Walk the descriptor one byte per cycle to the output register unless stalled
    smf_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (desc),
        .i_desc_valid (desc_valid),
        .i_dev_id     (r_dev_id),
        .o_take       (take),
        .o_res        (o_res)
    );

endmodule
